// ----- rtl/sfd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types, codes and constants of the SYN flood detector.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int DEF_PORT_ENTRIES     = 16;
    localparam int DEF_PENDING_PER_PORT = 256;
    localparam int DEF_LOCAL_ADDRS      = 4;

    localparam logic [8:0]  DEFAULT_THRESHOLD = 9'd200;
    localparam logic [15:0] MIN_FRAME_LEN     = 16'd14;
    localparam logic [7:0]  PROTO_TCP         = 8'd6;

    // configuration register indexes
    localparam logic [2:0] CFG_THRESHOLD  = 3'd0;
    localparam logic [2:0] CFG_ADDR_COUNT = 3'd1;
    localparam logic [2:0] CFG_ADDR_A     = 3'd2;
    localparam logic [2:0] CFG_ADDR_B     = 3'd3;
    localparam logic [2:0] CFG_ADDR_C     = 3'd4;
    localparam logic [2:0] CFG_ADDR_D     = 3'd5;

    typedef enum logic [2:0] {
        ST_IGNORED    = 3'd0,
        ST_RECORDED   = 3'd1,
        ST_ALARM      = 3'd2,
        ST_MATCHED    = 3'd3,
        ST_UNMATCHED  = 3'd4,
        ST_TABLE_FULL = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,       // load the item
        OP_PS_INIT,     // start port table walk
        OP_PS_STEP,     // check one port entry
        OP_ALLOC,       // claim the first free port entry
        OP_SWEEP_INIT,  // rewind pending list pointer
        OP_CLR_STEP,    // clear one pending entry
        OP_SCAN_STEP,   // read one pending entry
        OP_RECORD,      // write new half-open entry
        OP_MATCH,       // drop matched entry
        OP_ALARM,       // zero the port count, rewind for clear
        OP_OUT          // present the result
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        logic is_synack;
        logic is_ack;
        logic ps_done;
        logic ps_found;
        logic ps_free;
        logic sweep_last;
        logic scan_hit;
        logic scan_done;
        logic thr_hit;
    } t_dp_stat;

    typedef struct packed {
        logic        valid;
        logic [31:0] remote;
        logic [31:0] seq;
    } t_pend;

endpackage

// ----- rtl/syn_flood_detector.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// syn_flood_detector
// Counts half-open TCP connections per local address/port; raises alarms.
// ----------------------------------------------------------------------------
// Usage: pulse start with a parsed header while busy is low; exactly one
// result comes back on o_valid for one cycle and cannot be held off, so the
// receiver must take every transfer. An ignored item goes straight to its
// result; any other item walks the port table (up to PORT_ENTRIES entries)
// and, once its port is found or claimed, sweeps the port's pending list: a
// new port clears its list, the free-slot or ACK match scan reads one entry
// per cycle from the pending RAM, and an alarm clears the list again. A new
// port's scan stops at the first entry, so at most two full sweeps happen
// per item. No clearing pass after reset: a port's list is wiped when the
// port is claimed. Configuration writes must go in only while busy is low;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
module syn_flood_detector #(
    parameter int PORT_ENTRIES     = sfd_pkg::DEF_PORT_ENTRIES,
    parameter int PENDING_PER_PORT = sfd_pkg::DEF_PENDING_PER_PORT,
    parameter int LOCAL_ADDRS      = sfd_pkg::DEF_LOCAL_ADDRS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item transfer
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_frame_len,
    input  logic [7:0]  i_ip_protocol,
    input  logic [31:0] i_src_addr,
    input  logic [31:0] i_dst_addr,
    input  logic [15:0] i_src_port,
    input  logic [15:0] i_dst_port,
    input  logic        i_flag_syn,
    input  logic        i_flag_ack,
    input  logic [31:0] i_seq_num,
    input  logic [31:0] i_ack_num,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_data,
    // result transfer
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [31:0] o_alarm_addr,
    output logic [15:0] o_alarm_port,
    output logic [8:0]  o_open_count
);
    import sfd_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer: one item at a time
    sfd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // tables, pending RAM and result register
    sfd_dpath #(
        .PORT_ENTRIES     (PORT_ENTRIES),
        .PENDING_PER_PORT (PENDING_PER_PORT),
        .LOCAL_ADDRS      (LOCAL_ADDRS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame_len   (i_frame_len),
        .i_ip_protocol (i_ip_protocol),
        .i_src_addr    (i_src_addr),
        .i_dst_addr    (i_dst_addr),
        .i_src_port    (i_src_port),
        .i_dst_port    (i_dst_port),
        .i_flag_syn    (i_flag_syn),
        .i_flag_ack    (i_flag_ack),
        .i_seq_num     (i_seq_num),
        .i_ack_num     (i_ack_num),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_alarm_addr  (o_alarm_addr),
        .o_alarm_port  (o_alarm_port),
        .o_open_count  (o_open_count)
    );

endmodule

// ----- rtl/sfd_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/sfd_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_ctrl
// Sequencer: classify, port walk, list sweeps, threshold check, result.
// ----------------------------------------------------------------------------
module sfd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  sfd_pkg::t_dp_stat i_stat,
    output sfd_pkg::t_dp_cmd  o_cmd
);
    import sfd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_CLASS, S_PSRCH, S_CLR, S_SCAN, S_THR, S_ACLR, S_EMIT
    } t_state;

    t_state  r_state, n_state;
    t_status r_status, n_status;
    t_dp_cmd w_cmd;

    always_comb begin
        n_state    = r_state;
        n_status   = r_status;
        w_cmd.op     = OP_NONE;
        w_cmd.status = r_status;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    w_cmd.op = OP_LATCH;
                    n_state  = S_CLASS;
                end
            end
            S_CLASS: begin
                if (i_stat.is_synack || i_stat.is_ack) begin
                    w_cmd.op = OP_PS_INIT;
                    n_state  = S_PSRCH;
                end else begin
                    n_status = ST_IGNORED;
                    n_state  = S_EMIT;
                end
            end
            S_PSRCH: begin
                if (!i_stat.ps_done) begin
                    w_cmd.op = OP_PS_STEP;
                end else if (i_stat.ps_found) begin
                    w_cmd.op = OP_SWEEP_INIT;
                    n_state  = S_SCAN;
                end else if (i_stat.is_synack && i_stat.ps_free) begin
                    w_cmd.op = OP_ALLOC;
                    n_state  = S_CLR;
                end else begin
                    n_status = i_stat.is_synack ? ST_TABLE_FULL : ST_UNMATCHED;
                    n_state  = S_EMIT;
                end
            end
            S_CLR: begin
                w_cmd.op = OP_CLR_STEP;
                if (i_stat.sweep_last) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_hit) begin
                    if (i_stat.is_synack) begin
                        w_cmd.op = OP_RECORD;
                        n_state  = S_THR;
                    end else begin
                        w_cmd.op = OP_MATCH;
                        n_status = ST_MATCHED;
                        n_state  = S_EMIT;
                    end
                end else if (i_stat.scan_done) begin
                    if (i_stat.is_synack) begin
                        n_state = S_THR;
                    end else begin
                        n_status = ST_UNMATCHED;
                        n_state  = S_EMIT;
                    end
                end else begin
                    w_cmd.op = OP_SCAN_STEP;
                end
            end
            S_THR: begin
                if (i_stat.thr_hit) begin
                    w_cmd.op = OP_ALARM;
                    n_state  = S_ACLR;
                end else begin
                    n_status = ST_RECORDED;
                    n_state  = S_EMIT;
                end
            end
            S_ACLR: begin
                w_cmd.op = OP_CLR_STEP;
                if (i_stat.sweep_last) begin
                    n_status = ST_ALARM;
                    n_state  = S_EMIT;
                end
            end
            S_EMIT: begin
                w_cmd.op = OP_OUT;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_IGNORED;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_cmd  = w_cmd;

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted item did not raise busy");

    a_emit_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_OUT) |=> !o_busy)
        else $error("result issued without returning to idle");

    a_record_synack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_RECORD) |-> i_stat.is_synack)
        else $error("record issued for a non SYN+ACK item");

endmodule

// ----- rtl/sfd_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_dpath
// Item registers, config, port table, pending list RAM and result register.
// ----------------------------------------------------------------------------
module sfd_dpath #(
    parameter int PORT_ENTRIES     = sfd_pkg::DEF_PORT_ENTRIES,
    parameter int PENDING_PER_PORT = sfd_pkg::DEF_PENDING_PER_PORT,
    parameter int LOCAL_ADDRS      = sfd_pkg::DEF_LOCAL_ADDRS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [15:0]       i_frame_len,
    input  logic [7:0]        i_ip_protocol,
    input  logic [31:0]       i_src_addr,
    input  logic [31:0]       i_dst_addr,
    input  logic [15:0]       i_src_port,
    input  logic [15:0]       i_dst_port,
    input  logic              i_flag_syn,
    input  logic              i_flag_ack,
    input  logic [31:0]       i_seq_num,
    input  logic [31:0]       i_ack_num,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_addr,
    input  logic [31:0]       i_cfg_data,
    input  sfd_pkg::t_dp_cmd  i_cmd,
    output sfd_pkg::t_dp_stat o_stat,
    output logic              o_valid,
    output logic [2:0]        o_status,
    output logic [31:0]       o_alarm_addr,
    output logic [15:0]       o_alarm_port,
    output logic [8:0]        o_open_count
);
    import sfd_pkg::*;

    localparam int PIDX_W = $clog2(PORT_ENTRIES);
    localparam int PCNT_W = $clog2(PORT_ENTRIES + 1);
    localparam int K_W    = $clog2(PENDING_PER_PORT);
    localparam int KC_W   = $clog2(PENDING_PER_PORT + 1);
    localparam int AW     = $clog2(PORT_ENTRIES * PENDING_PER_PORT);
    localparam int CMP_W  = (KC_W > 9) ? KC_W : 9;
    localparam int PW     = $bits(t_pend);

    // item
    logic [15:0] r_len, r_sport, r_dport;
    logic [7:0]  r_proto;
    logic [31:0] r_src, r_dst, r_seq, r_acknum;
    logic        r_syn, r_ack;

    // config
    logic [8:0]  r_thr;
    logic [2:0]  r_lcnt;
    logic [31:0] r_laddr [4];

    // port table
    logic              r_pv [PORT_ENTRIES];
    logic [31:0]       r_pa [PORT_ENTRIES];
    logic [15:0]       r_pn [PORT_ENTRIES];
    logic [KC_W-1:0]   r_pc [PORT_ENTRIES];

    // walk state
    logic [PCNT_W-1:0] r_pidx;
    logic              r_found, r_free;
    logic [PIDX_W-1:0] r_sel, r_fidx;
    logic [KC_W-1:0]   r_cnt;
    logic [KC_W-1:0]   r_k;
    logic              r_rdv;
    logic [K_W-1:0]    r_chk;

    // result
    logic        r_ovalid;
    t_status     r_ostatus;
    logic [31:0] r_oaddr;
    logic [15:0] r_oport;
    logic [8:0]  r_ocnt;

    logic              w_frame_ok, w_src_local, w_dst_local;
    logic              w_synack, w_pack;
    logic [31:0]       w_key_addr;
    logic [15:0]       w_key_port;
    logic [PIDX_W-1:0] w_idx;
    logic              w_hit_entry;
    logic [AW-1:0]     w_base;
    logic              w_we, w_re;
    logic [AW-1:0]     w_waddr, w_raddr;
    t_pend             w_wdata, w_rdata;
    logic [PW-1:0]     w_rdata_raw;
    logic [CMP_W-1:0]  w_eff_thr;
    logic              w_match;
    logic              w_k_end;

    always_comb begin
        w_src_local = 1'b0;
        w_dst_local = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (i < LOCAL_ADDRS && 3'(i) < r_lcnt) begin
                if (r_laddr[i] == r_src) w_src_local = 1'b1;
                if (r_laddr[i] == r_dst) w_dst_local = 1'b1;
            end
        end
    end

    assign w_frame_ok = (r_len > MIN_FRAME_LEN) && (r_proto == PROTO_TCP);
    assign w_synack   = w_frame_ok && r_syn && r_ack && w_src_local;
    assign w_pack     = w_frame_ok && !r_syn && r_ack && w_dst_local;
    assign w_key_addr = w_synack ? r_src : r_dst;
    assign w_key_port = w_synack ? r_sport : r_dport;

    assign w_idx       = r_pidx[PIDX_W-1:0];
    assign w_hit_entry = r_pv[w_idx] && (r_pa[w_idx] == w_key_addr)
                         && (r_pn[w_idx] == w_key_port);

    assign w_base  = AW'(AW'(r_sel) * AW'(PENDING_PER_PORT));
    assign w_k_end = (r_k == KC_W'(PENDING_PER_PORT));

    // threshold: zero acts as one, capped at list length
    always_comb begin
        if (r_thr == 9'd0) begin
            w_eff_thr = CMP_W'(1);
        end else if (CMP_W'(r_thr) > CMP_W'(PENDING_PER_PORT)) begin
            w_eff_thr = CMP_W'(PENDING_PER_PORT);
        end else begin
            w_eff_thr = CMP_W'(r_thr);
        end
    end

    assign w_rdata = t_pend'(w_rdata_raw);
    assign w_match = w_rdata.valid && ((w_rdata.seq + 32'd1) == r_acknum)
                     && (w_rdata.remote == r_src);

    // pending RAM ports
    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_base + AW'(r_chk);
        w_wdata = '{valid: 1'b0, remote: r_dst, seq: r_seq};
        w_re    = 1'b0;
        w_raddr = w_base + AW'(r_k[K_W-1:0]);
        case (i_cmd.op)
            OP_CLR_STEP: begin
                w_we    = 1'b1;
                w_waddr = w_base + AW'(r_k[K_W-1:0]);
            end
            OP_RECORD: begin
                w_we          = 1'b1;
                w_wdata.valid = 1'b1;
            end
            OP_MATCH: begin
                w_we = 1'b1;
            end
            OP_SCAN_STEP: begin
                w_re = !w_k_end;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    sfd_ram #(
        .WIDTH (PW),
        .DEPTH (PORT_ENTRIES * PENDING_PER_PORT)
    ) u_pend (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_raw)
    );

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= DEFAULT_THRESHOLD;
            r_lcnt <= 3'd0;
            for (int i = 0; i < 4; i++) r_laddr[i] <= 32'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_THRESHOLD:  r_thr      <= i_cfg_data[8:0];
                CFG_ADDR_COUNT: r_lcnt     <= i_cfg_data[2:0];
                CFG_ADDR_A:     r_laddr[0] <= i_cfg_data;
                CFG_ADDR_B:     r_laddr[1] <= i_cfg_data;
                CFG_ADDR_C:     r_laddr[2] <= i_cfg_data;
                CFG_ADDR_D:     r_laddr[3] <= i_cfg_data;
                default:        r_thr      <= r_thr;
            endcase
        end
    end

    // item payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LATCH) begin
            r_len    <= i_frame_len;
            r_proto  <= i_ip_protocol;
            r_src    <= i_src_addr;
            r_dst    <= i_dst_addr;
            r_sport  <= i_src_port;
            r_dport  <= i_dst_port;
            r_syn    <= i_flag_syn;
            r_ack    <= i_flag_ack;
            r_seq    <= i_seq_num;
            r_acknum <= i_ack_num;
        end
    end

    // port table and walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PORT_ENTRIES; i++) begin
                r_pv[i] <= 1'b0;
                r_pc[i] <= '0;
            end
            r_pidx   <= '0;
            r_found  <= 1'b0;
            r_free   <= 1'b0;
            r_sel    <= '0;
            r_fidx   <= '0;
            r_cnt    <= '0;
            r_k      <= '0;
            r_rdv    <= 1'b0;
            r_chk    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= 1'b0;
            case (i_cmd.op)
                OP_LATCH: begin
                    r_cnt <= '0;
                end
                OP_PS_INIT: begin
                    r_pidx  <= '0;
                    r_found <= 1'b0;
                    r_free  <= 1'b0;
                    r_cnt   <= '0;
                end
                OP_PS_STEP: begin
                    if (w_hit_entry) begin
                        r_found <= 1'b1;
                        r_sel   <= w_idx;
                        r_cnt   <= r_pc[w_idx];
                    end else if (!r_pv[w_idx] && !r_free) begin
                        r_free <= 1'b1;
                        r_fidx <= w_idx;
                    end
                    r_pidx <= r_pidx + PCNT_W'(1);
                end
                OP_ALLOC: begin
                    r_pv[r_fidx] <= 1'b1;
                    r_pa[r_fidx] <= w_key_addr;
                    r_pn[r_fidx] <= w_key_port;
                    r_pc[r_fidx] <= '0;
                    r_sel        <= r_fidx;
                    r_cnt        <= '0;
                    r_k          <= '0;
                    r_rdv        <= 1'b0;
                end
                OP_SWEEP_INIT: begin
                    r_k   <= '0;
                    r_rdv <= 1'b0;
                end
                OP_CLR_STEP: begin
                    r_rdv <= 1'b0;
                    if (r_k == KC_W'(PENDING_PER_PORT - 1)) begin
                        r_k <= '0;
                    end else begin
                        r_k <= r_k + KC_W'(1);
                    end
                end
                OP_SCAN_STEP: begin
                    if (!w_k_end) begin
                        r_chk <= r_k[K_W-1:0];
                        r_k   <= r_k + KC_W'(1);
                        r_rdv <= 1'b1;
                    end else begin
                        r_rdv <= 1'b0;
                    end
                end
                OP_RECORD: begin
                    r_cnt        <= r_cnt + KC_W'(1);
                    r_pc[r_sel]  <= r_cnt + KC_W'(1);
                end
                OP_MATCH: begin
                    if (r_cnt != '0) begin
                        r_cnt       <= r_cnt - KC_W'(1);
                        r_pc[r_sel] <= r_cnt - KC_W'(1);
                    end
                end
                OP_ALARM: begin
                    r_cnt       <= '0;
                    r_pc[r_sel] <= '0;
                    r_k         <= '0;
                    r_rdv       <= 1'b0;
                end
                OP_OUT: begin
                    r_ovalid <= 1'b1;
                end
                default: begin
                    r_ovalid <= 1'b0;
                end
            endcase
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_OUT) begin
            r_ostatus <= i_cmd.status;
            r_ocnt    <= 9'(r_cnt);
            if (i_cmd.status == ST_ALARM) begin
                r_oaddr <= r_src;
                r_oport <= r_sport;
            end else begin
                r_oaddr <= 32'd0;
                r_oport <= 16'd0;
            end
        end
    end

    assign o_stat.is_synack  = w_synack;
    assign o_stat.is_ack     = w_pack;
    assign o_stat.ps_done    = r_found || (r_pidx == PCNT_W'(PORT_ENTRIES));
    assign o_stat.ps_found   = r_found;
    assign o_stat.ps_free    = r_free;
    assign o_stat.sweep_last = (r_k == KC_W'(PENDING_PER_PORT - 1));
    assign o_stat.scan_hit   = r_rdv && (w_synack ? !w_rdata.valid : w_match);
    assign o_stat.scan_done  = !r_rdv && w_k_end;
    assign o_stat.thr_hit    = (CMP_W'(r_cnt) >= w_eff_thr);

    assign o_valid      = r_ovalid;
    assign o_status     = r_ostatus;
    assign o_alarm_addr = r_oaddr;
    assign o_alarm_port = r_oport;
    assign o_open_count = r_ocnt;

    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("back-to-back result strobes");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= KC_W'(PENDING_PER_PORT))
        else $error("open count beyond list length");

    a_alarm_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_ALARM) |-> (o_open_count == 9'd0))
        else $error("alarm with nonzero open count");

endmodule
